[src/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros shared by the checker files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while the active-low reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication held on every clock edge out of reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    `ASSERT_CLK(label, clk, rst_n, (ante) |-> (cons), msg)

`endif

[src/rfm_pkg.sv]
// ---------------------------------------------------------------------------
// rfm_pkg
// Types and constants shared by the recursive FIFO mutex block.
// ---------------------------------------------------------------------------
package rfm_pkg;

    localparam int DEPTH_W  = 8;
    localparam int STATUS_W = 3;

    // Request kinds
    localparam logic KIND_ACQUIRE = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_GRANT_NEW  = 3'd0,
        ST_GRANT_NEST = 3'd1,
        ST_QUEUED     = 3'd2,
        ST_DEC        = 3'd3,
        ST_FREED      = 3'd4,
        ST_HANDOFF    = 3'd5,
        ST_ERR_FULL   = 3'd6,
        ST_ERR_OWNER  = 3'd7
    } t_status;

    // Controller states, one-hot
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EVAL = 2'b10
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load_req;
        logic commit;
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

[src/recursive_fifo_mutex_top.sv]
// Recursive FIFO mutex: each request (acquire or release with a thread id)
// passes through the controller states S_IDLE and S_EVAL. In the accepting
// cycle the request is latched and the head of the wait FIFO memory is read.
// In S_EVAL the block decides and commits once the output register is free,
// so the result then sits there. The registered read of that memory is why
// the decision waits for S_EVAL. No new request is taken until the previous
// one is committed, but one may be accepted while the previous result still
// waits in the output register. Ownership hand-off pops the oldest waiter;
// the wait FIFO holds WAIT_DEPTH ids and needs no clearing after reset.
// ---------------------------------------------------------------------------
// recursive_fifo_mutex_top
// Top level: controller plus datapath with a one-register config port.
// ---------------------------------------------------------------------------
module recursive_fifo_mutex_top
    import rfm_pkg::*;
#(
    parameter int WAIT_DEPTH = 16,
    parameter int ID_BITS    = 8,
    parameter int MAX_NEST   = 255
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_kind,
    input  logic [ID_BITS-1:0]  i_thread_id,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic                o_woken_valid,
    output logic [ID_BITS-1:0]  o_woken_thread,
    output logic [DEPTH_W-1:0]  o_depth_now,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_data
);

    t_ctrl_cmd  cmd;
    t_dp_status sts;

    // Config writes are always taken
    assign o_cfg_ready = 1'b1;

    rfm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rfm_datapath #(
        .WAIT_DEPTH (WAIT_DEPTH),
        .ID_BITS    (ID_BITS),
        .MAX_NEST   (MAX_NEST)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_kind         (i_kind),
        .i_thread_id    (i_thread_id),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_status       (o_status),
        .o_woken_valid  (o_woken_valid),
        .o_woken_thread (o_woken_thread),
        .o_depth_now    (o_depth_now)
    );

endmodule

[src/rfm_ctrl.sv]
// ---------------------------------------------------------------------------
// rfm_ctrl
// Sequencer: takes one request, lets the datapath evaluate it and commits
// the result once the output register can take it.
// ---------------------------------------------------------------------------
module rfm_ctrl
    import rfm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_dp_status i_sts,
    output t_ctrl_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // Handshake and commands
    assign o_in_stall     = (r_state != S_IDLE);
    assign o_cmd.load_req = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.commit   = (r_state == S_EVAL) && i_sts.out_free;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EVAL;
            end
            S_EVAL: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[src/rfm_datapath.sv]
// ---------------------------------------------------------------------------
// rfm_datapath
// Owner, nesting depth, wait FIFO memory, decision logic and the output
// register.
// ---------------------------------------------------------------------------
module rfm_datapath
    import rfm_pkg::*;
#(
    parameter int WAIT_DEPTH = 16,
    parameter int ID_BITS    = 8,
    parameter int MAX_NEST   = 255
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_ctrl_cmd           i_cmd,
    output t_dp_status          o_sts,
    input  logic                i_kind,
    input  logic [ID_BITS-1:0]  i_thread_id,
    input  logic                i_cfg_we,
    input  logic                i_cfg_data,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic                o_woken_valid,
    output logic [ID_BITS-1:0]  o_woken_thread,
    output logic [DEPTH_W-1:0]  o_depth_now
);

    localparam int AW = $clog2(WAIT_DEPTH);
    localparam int CW = $clog2(WAIT_DEPTH + 1);
    localparam logic [AW-1:0]      LAST_SLOT = AW'(WAIT_DEPTH - 1);
    localparam logic [CW-1:0]      FULL_CNT  = CW'(WAIT_DEPTH);
    localparam logic [DEPTH_W-1:0] NEST_LIM  = DEPTH_W'(MAX_NEST);
    localparam logic [DEPTH_W-1:0] ONE_LVL   = DEPTH_W'(1);

    // Latched request and mode
    logic               r_kind;
    logic [ID_BITS-1:0] r_tid;
    logic               r_mode;

    // Mutex state
    logic [ID_BITS-1:0] r_owner_id,    n_owner_id;
    logic               r_owner_valid, n_owner_valid;
    logic [DEPTH_W-1:0] r_depth,       n_depth;
    logic [AW-1:0]      r_head,        n_head;
    logic [AW-1:0]      r_tail,        n_tail;
    logic [CW-1:0]      r_count,       n_count;

    // Wait FIFO storage, head entry read every cycle
    logic [ID_BITS-1:0] r_wait_mem [WAIT_DEPTH];
    logic [ID_BITS-1:0] r_rd_data;

    // Output register
    logic               r_out_valid;
    t_status            r_status,  n_status;
    logic               r_wv,      n_wv;
    logic [ID_BITS-1:0] r_woken,   n_woken;
    logic [DEPTH_W-1:0] r_dnow,    n_dnow;

    logic               push;
    logic               is_holder;
    logic [DEPTH_W-1:0] limit;

    assign is_holder = r_owner_valid && (r_owner_id == r_tid);
    assign limit     = r_mode ? NEST_LIM : ONE_LVL;

    // Request decision
    always_comb begin
        n_owner_id    = r_owner_id;
        n_owner_valid = r_owner_valid;
        n_depth       = r_depth;
        n_head        = r_head;
        n_tail        = r_tail;
        n_count       = r_count;
        n_wv          = 1'b0;
        n_woken       = '0;
        push          = 1'b0;
        n_status      = ST_ERR_OWNER;
        if (r_kind == KIND_ACQUIRE) begin
            priority if (is_holder) begin
                if (r_depth < limit) begin
                    n_depth  = r_depth + ONE_LVL;
                    n_status = ST_GRANT_NEST;
                end else begin
                    n_status = ST_ERR_FULL;
                end
            end else if (!r_owner_valid) begin
                n_owner_valid = 1'b1;
                n_owner_id    = r_tid;
                n_depth       = ONE_LVL;
                n_status      = ST_GRANT_NEW;
            end else if (r_count < FULL_CNT) begin
                push     = 1'b1;
                n_tail   = (r_tail == LAST_SLOT) ? '0 : r_tail + AW'(1);
                n_count  = r_count + CW'(1);
                n_status = ST_QUEUED;
            end else begin
                n_status = ST_ERR_FULL;
            end
        end else begin
            priority if (!is_holder) begin
                n_status = ST_ERR_OWNER;
            end else if (r_depth > ONE_LVL) begin
                n_depth  = r_depth - ONE_LVL;
                n_status = ST_DEC;
            end else if (r_count != '0) begin
                n_woken    = r_rd_data;
                n_wv       = 1'b1;
                n_head     = (r_head == LAST_SLOT) ? '0 : r_head + AW'(1);
                n_count    = r_count - CW'(1);
                n_owner_id = r_rd_data;
                n_depth    = ONE_LVL;
                n_status   = ST_HANDOFF;
            end else begin
                n_owner_valid = 1'b0;
                n_owner_id    = '0;
                n_depth       = '0;
                n_status      = ST_FREED;
            end
        end
        n_dnow = n_owner_valid ? n_depth : '0;
    end

    // Request latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_kind <= i_kind;
            r_tid  <= i_thread_id;
        end
    end

    // Control state and mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= 1'b0;
            r_owner_id    <= '0;
            r_owner_valid <= 1'b0;
            r_depth       <= '0;
            r_head        <= '0;
            r_tail        <= '0;
            r_count       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) r_mode <= i_cfg_data;
            if (i_cmd.commit) begin
                r_owner_id    <= n_owner_id;
                r_owner_valid <= n_owner_valid;
                r_depth       <= n_depth;
                r_head        <= n_head;
                r_tail        <= n_tail;
                r_count       <= n_count;
                r_out_valid   <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    // FIFO memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && push) r_wait_mem[r_tail] <= r_tid;
        r_rd_data <= r_wait_mem[r_head];
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status <= n_status;
            r_wv     <= n_wv;
            r_woken  <= n_woken;
            r_dnow   <= n_dnow;
        end
    end

    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_woken_valid  = r_wv;
    assign o_woken_thread = r_woken;
    assign o_depth_now    = r_dnow;

endmodule

[src/rfm_checker.sv]
// ---------------------------------------------------------------------------
// rfm_checker
// Port-level checks on results of the recursive FIFO mutex.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rfm_checker
    import rfm_pkg::*;
#(
    parameter int ID_BITS = 8
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input logic [STATUS_W-1:0] o_status,
    input logic                o_woken_valid,
    input logic [ID_BITS-1:0]  o_woken_thread,
    input logic [DEPTH_W-1:0]  o_depth_now
);

    // A stalled result stays offered
    `ASSERT_IMPL(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, ##1 o_out_valid, "result dropped while stalled")

    // Wake flag goes with a hand-off status only
    `ASSERT_IMPL(a_wake_status, i_clk, i_rst_n, o_out_valid, o_woken_valid == (o_status == ST_HANDOFF), "wake flag and status disagree")

    // No woken id without a hand-off
    `ASSERT_IMPL(a_wake_zero, i_clk, i_rst_n, o_out_valid && !o_woken_valid, o_woken_thread == '0, "woken id set without hand-off")

    // Fresh ownership starts at depth one, a freed mutex reports zero
    `ASSERT_IMPL(a_depth_fresh, i_clk, i_rst_n, o_out_valid && (o_status == ST_GRANT_NEW || o_status == ST_HANDOFF || o_status == ST_FREED), o_depth_now == ((o_status == ST_FREED) ? 8'd0 : 8'd1), "depth wrong after grant, hand-off or free")

endmodule

bind recursive_fifo_mutex_top rfm_checker #(.ID_BITS(ID_BITS)) u_rfm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_status       (o_status),
    .o_woken_valid  (o_woken_valid),
    .o_woken_thread (o_woken_thread),
    .o_depth_now    (o_depth_now)
);
